>>> src/pgr_pkg.sv
// ----------------------------------------------------------------------------
// pgr_pkg
// Shared types and constants of the pan gesture recognizer.
// ----------------------------------------------------------------------------
package pgr_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int MAX_TOUCHES    = 4;
	localparam int ID_LANES       = 4;
	localparam int LANE_LIMIT     = (MAX_TOUCHES < ID_LANES) ? MAX_TOUCHES : ID_LANES;
	localparam int CNT_W          = $clog2(ID_LANES + 1);
	localparam int ID_W           = 8;
	localparam int VEL_W          = 16;
	localparam int THRESH_W       = 26;
	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(100);
	localparam logic [ID_W-1:0]     NO_TOUCH     = '1;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_THRESH = 1'b0;

	typedef enum logic [2:0] {
		KIND_BEGIN   = 3'd0,
		KIND_END     = 3'd1,
		KIND_MOVE    = 3'd2,
		KIND_CANCEL  = 3'd3,
		KIND_RELEASE = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		GS_BEGAN     = 2'd0,
		GS_CHANGED   = 2'd1,
		GS_ENDED     = 2'd2,
		GS_CANCELLED = 2'd3
	} gesture_t;

	typedef struct packed {
		logic hit;         // id equals tracked touch
		logic cancel_hit;  // hit, and lane within the touch count
	} lane_hit_t;

	typedef struct packed {
		logic             load;
		logic [CNT_W-1:0] count;
	} out_load_t;

endpackage

>>> src/pgr_if.sv
// ----------------------------------------------------------------------------
// pgr_evt_if / pgr_rpt_if
// Valid/ready channels for touch events and gesture reports.
// ----------------------------------------------------------------------------
interface pgr_evt_if #(
	parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
);
	logic                                valid;
	logic                                ready;
	logic [2:0]                          kind;
	logic [2:0]                          touch_count;
	logic signed [pgr_pkg::ID_W-1:0]     touch_id_0;
	logic signed [pgr_pkg::ID_W-1:0]     touch_id_1;
	logic signed [pgr_pkg::ID_W-1:0]     touch_id_2;
	logic signed [pgr_pkg::ID_W-1:0]     touch_id_3;
	logic [COORD_BITS-1:0]               pos_x_in;
	logic [COORD_BITS-1:0]               pos_y_in;
	logic signed [pgr_pkg::VEL_W-1:0]    vel_x_in;
	logic signed [pgr_pkg::VEL_W-1:0]    vel_y_in;

	modport source (
		output valid, kind, touch_count, touch_id_0, touch_id_1, touch_id_2, touch_id_3,
		output pos_x_in, pos_y_in, vel_x_in, vel_y_in,
		input  ready
	);
	modport sink (
		input  valid, kind, touch_count, touch_id_0, touch_id_1, touch_id_2, touch_id_3,
		input  pos_x_in, pos_y_in, vel_x_in, vel_y_in,
		output ready
	);
endinterface

interface pgr_rpt_if #(
	parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic [1:0]                        gesture_state;
	logic signed [COORD_BITS:0]        report_x;
	logic signed [COORD_BITS:0]        report_y;
	logic signed [pgr_pkg::VEL_W-1:0]  report_vel_x;
	logic signed [pgr_pkg::VEL_W-1:0]  report_vel_y;
	logic                              last_of_run;

	modport source (
		output valid, gesture_state, report_x, report_y, report_vel_x, report_vel_y,
		output last_of_run,
		input  ready
	);
	modport sink (
		input  valid, gesture_state, report_x, report_y, report_vel_x, report_vel_y,
		input  last_of_run,
		output ready
	);
endinterface

>>> src/pan_gesture_recognizer.sv
// ----------------------------------------------------------------------------
// pan_gesture_recognizer
// Tracks one touch and reports pan gestures (began, changed, ended,
// cancelled) from a stream of touch events.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          carries
//  evt      in   valid/ready        one touch event per request
//  rpt      out  valid/ready        one gesture report per request
//  apb      in   psel/penable       distance_threshold_sq at byte address 0
//
//  An event is decided in the cycle it is accepted; its reports appear on
//  rpt from the next cycle. One event per cycle while rpt keeps up.
//  A cancel with k matching lanes holds evt while the report register
//  replays its k copies. Events without reports pass even then only
//  once the register is free or frees that cycle.
//  Reset clears tracking and loads the threshold with 100; no clearing pass.
// ----------------------------------------------------------------------------
module pan_gesture_recognizer #(
	parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	pgr_evt_if.sink                      evt,
	pgr_rpt_if.source                    rpt,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pgr_pkg::APB_AW-1:0]   paddr,
	input  logic [pgr_pkg::APB_DW-1:0]   pwdata,
	output logic [pgr_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	import pgr_pkg::*;

	localparam int D2_W  = 2 * COORD_BITS + 2;
	localparam int CMP_W = (D2_W > THRESH_W) ? D2_W : THRESH_W;

	// configuration
	logic [THRESH_W-1:0] thresh_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THRESH) ? APB_DW'(thresh_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESH)) begin
			thresh_q <= pwdata[THRESH_W-1:0];
		end
	end

	// tracking state
	logic [ID_W-1:0]       tracked_q;
	logic [COORD_BITS-1:0] org_x_q;
	logic [COORD_BITS-1:0] org_y_q;
	logic                  recog_q;
	logic                  nyr_q;

	// id lanes
	logic [ID_W-1:0]  ids [ID_LANES];
	lane_hit_t        hits [ID_LANES];
	logic [ID_LANES-1:0] cancel_vec;

	assign ids[0] = evt.touch_id_0;
	assign ids[1] = evt.touch_id_1;
	assign ids[2] = evt.touch_id_2;
	assign ids[3] = evt.touch_id_3;

	for (genvar i = 0; i < ID_LANES; i++) begin : g_lane
		pgr_lane u_lane (
			.id        (ids[i]),
			.tracked_id(tracked_q),
			.enable    ((i < LANE_LIMIT) && (32'(evt.touch_count) > i)),
			.result    (hits[i])
		);
		assign cancel_vec[i] = hits[i].cancel_hit;
	end

	// distance check
	logic signed [COORD_BITS:0] dx, dy;
	logic [D2_W-1:0]            dx2, dy2, d2;
	logic                       far;

	assign dx  = $signed({1'b0, evt.pos_x_in}) - $signed({1'b0, org_x_q});
	assign dy  = $signed({1'b0, evt.pos_y_in}) - $signed({1'b0, org_y_q});
	// square at full width so the product cannot wrap at the delta width
	assign dx2 = $unsigned(D2_W'(dx) * D2_W'(dx));
	assign dy2 = $unsigned(D2_W'(dy) * D2_W'(dy));
	assign d2  = dx2 + dy2;
	assign far = CMP_W'(d2) > CMP_W'(thresh_q);

	// decision and merge
	logic                       take;
	logic                       can_take;
	out_load_t                  ld;
	logic [1:0]                 gs;
	logic signed [COORD_BITS:0] rx, ry;
	logic signed [VEL_W-1:0]    vx, vy;
	logic [ID_W-1:0]            tracked_d;
	logic [COORD_BITS-1:0]      org_x_d, org_y_d;
	logic                       recog_d, nyr_d, do_cancel;

	assign evt.ready = can_take;
	assign take      = evt.valid && can_take;

	always_comb begin
		tracked_d = tracked_q;
		org_x_d   = org_x_q;
		org_y_d   = org_y_q;
		recog_d   = recog_q;
		nyr_d     = nyr_q;
		ld.count  = '0;
		gs        = GS_CANCELLED;
		rx        = '0;
		ry        = '0;
		vx        = '0;
		vy        = '0;
		do_cancel = 1'b0;
		unique case (evt.kind)
			KIND_BEGIN: begin
				if (!evt.touch_id_0[ID_W-1]) begin
					org_x_d   = evt.pos_x_in;
					org_y_d   = evt.pos_y_in;
					tracked_d = evt.touch_id_0;
				end
			end
			KIND_END: begin
				if (hits[0].hit && recog_q) begin
					ld.count = CNT_W'(1);
					gs       = GS_ENDED;
					rx       = $signed({1'b0, evt.pos_x_in});
					ry       = $signed({1'b0, evt.pos_y_in});
					vx       = evt.vel_x_in;
					vy       = evt.vel_y_in;
					nyr_d    = 1'b1;
					recog_d  = 1'b0;
				end
			end
			KIND_MOVE: begin
				if (evt.touch_count != 3'd1) begin
					do_cancel = 1'b1;
				end else if (hits[0].hit && far) begin
					ld.count = CNT_W'(1);
					gs       = (!recog_q || nyr_q) ? GS_BEGAN : GS_CHANGED;
					rx       = dx;
					ry       = dy;
					vx       = evt.vel_x_in;
					vy       = evt.vel_y_in;
					recog_d  = 1'b1;
					nyr_d    = 1'b0;
					org_x_d  = evt.pos_x_in;
					org_y_d  = evt.pos_y_in;
				end
			end
			KIND_CANCEL: begin
				do_cancel = 1'b1;
			end
			KIND_RELEASE: begin
				recog_d   = 1'b0;
				nyr_d     = 1'b1;
				tracked_d = NO_TOUCH;
			end
			default: begin
			end
		endcase
		// cancel merges the lane hits into a repeat count
		if (do_cancel && recog_q) begin
			ld.count  = CNT_W'($countones(cancel_vec));
			gs        = GS_CANCELLED;
			nyr_d     = 1'b1;
			recog_d   = 1'b0;
			tracked_d = NO_TOUCH;
		end
		ld.load = take && (ld.count != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= NO_TOUCH;
			org_x_q   <= '0;
			org_y_q   <= '0;
			recog_q   <= 1'b0;
			nyr_q     <= 1'b1;
		end else if (take) begin
			tracked_q <= tracked_d;
			org_x_q   <= org_x_d;
			org_y_q   <= org_y_d;
			recog_q   <= recog_d;
			nyr_q     <= nyr_d;
		end
	end

	pgr_out #(
		.COORD_BITS(COORD_BITS)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.ld      (ld),
		.gs      (gs),
		.rx      (rx),
		.ry      (ry),
		.vx      (vx),
		.vy      (vy),
		.can_take(can_take),
		.rpt     (rpt)
	);

endmodule

>>> src/pgr_lane.sv
// ----------------------------------------------------------------------------
// pgr_lane
// One id lane: compares a touch id against the tracked touch.
// ----------------------------------------------------------------------------
module pgr_lane (
	input  logic [pgr_pkg::ID_W-1:0] id,
	input  logic [pgr_pkg::ID_W-1:0] tracked_id,
	input  logic                     enable,
	output pgr_pkg::lane_hit_t       result
);
	import pgr_pkg::*;

	// a negative tracked id means no touch and matches nothing
	assign result.hit        = !tracked_id[ID_W-1] && (id == tracked_id);
	assign result.cancel_hit = result.hit && enable;

endmodule

>>> src/pgr_out.sv
// ----------------------------------------------------------------------------
// pgr_out
// Report register: holds one report and replays it count times,
// flagging the final copy.
// ----------------------------------------------------------------------------
module pgr_out #(
	parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pgr_pkg::out_load_t              ld,
	input  logic [1:0]                      gs,
	input  logic signed [COORD_BITS:0]      rx,
	input  logic signed [COORD_BITS:0]      ry,
	input  logic signed [pgr_pkg::VEL_W-1:0] vx,
	input  logic signed [pgr_pkg::VEL_W-1:0] vy,
	output logic                            can_take,
	pgr_rpt_if.source                       rpt
);
	import pgr_pkg::*;

	logic [CNT_W-1:0]           cnt_q;
	logic [1:0]                 gs_q;
	logic signed [COORD_BITS:0] rx_q;
	logic signed [COORD_BITS:0] ry_q;
	logic signed [VEL_W-1:0]    vx_q;
	logic signed [VEL_W-1:0]    vy_q;
	logic                       fire;

	assign fire     = rpt.valid && rpt.ready;
	// free now, or the last pending copy leaves this cycle
	assign can_take = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && rpt.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ld.load) begin
			cnt_q <= ld.count;
		end else if (fire) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			gs_q <= gs;
			rx_q <= rx;
			ry_q <= ry;
			vx_q <= vx;
			vy_q <= vy;
		end
	end

	assign rpt.valid         = (cnt_q != '0);
	assign rpt.last_of_run   = (cnt_q == CNT_W'(1));
	assign rpt.gesture_state = gs_q;
	assign rpt.report_x      = rx_q;
	assign rpt.report_y      = ry_q;
	assign rpt.report_vel_x  = vx_q;
	assign rpt.report_vel_y  = vy_q;

endmodule
